[src/bzdc_pkg.sv]
// Shared constants and types for the de Casteljau Bezier evaluator.
// Used by bzdc_lerp and bezier_de_casteljau_eval_core; no dependencies.

package bzdc_pkg;

    // Default sizing for the point store and coordinate datapath
    localparam int MAX_POINTS_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 32;

    // Stream field widths
    localparam int CFG_W     = 5;   // active_points register
    localparam int IDX_W     = 4;   // point_index
    localparam int XY_W      = 32;  // point_x, point_y, curve_x, curve_y
    localparam int T_W       = 17;  // curve_param, Q1.16
    localparam int S_DATA_W  = 88;  // 85 payload bits padded to whole bytes
    localparam int S_USER_W  = 1;
    localparam int M_DATA_W  = 64;

    // Input tdata bit offsets
    localparam int IDX_LSB = 0;
    localparam int PX_LSB  = IDX_LSB + IDX_W;
    localparam int PY_LSB  = PX_LSB + XY_W;
    localparam int T_LSB   = PY_LSB + XY_W;

    // t = 1.0 in Q1.16
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // Commands carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Per-cycle control of one lerp lane
    typedef struct packed {
        logic take;   // latch new q as the next p
        logic step;   // compute lerp of held p toward q
    } lerp_ctl_t;

endpackage

[src/bzdc_lerp.sv]
// One coordinate lane of the lerp datapath: p + floor(t * (q - p) / 2^16).
// Depends on bzdc_pkg for lerp_ctl_t and T_W.

module bzdc_lerp #(
    parameter int COORD_WIDTH = bzdc_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  bzdc_pkg::lerp_ctl_t             ctl,
    input  logic signed [COORD_WIDTH-1:0]   q,
    input  logic [bzdc_pkg::T_W-1:0]        t,
    output logic signed [COORD_WIDTH-1:0]   sum
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = DIFF_W + bzdc_pkg::T_W + 1;

    logic signed [COORD_WIDTH-1:0] p_reg;
    logic signed [COORD_WIDTH-1:0] base_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      scaled;
    logic signed [PROD_W-1:0]      sum_wide;

    // Difference and product, registered before the add
    assign diff      = DIFF_W'(q) - DIFF_W'(p_reg);
    assign prod_next = PROD_W'(diff) * $signed({1'b0, t});

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            p_reg <= q;
        end
        if (ctl.step)
        begin
            prod_reg <= prod_next;
            base_reg <= p_reg;
        end
    end

    // Arithmetic shift gives floor; result lies between p and q
    assign scaled   = prod_reg >>> 16;
    assign sum_wide = PROD_W'(base_reg) + scaled;
    assign sum      = sum_wide[COORD_WIDTH-1:0];

endmodule

[src/bezier_de_casteljau_eval_core.sv]
// Top level of the de Casteljau Bezier evaluator: point store, work store,
// reduction sequencer and output register. Depends on bzdc_pkg, bzdc_lerp.

// Usage
//   Slave stream (s_*): one transaction is a load (tuser = 0) that writes a
//   control point at point_index, or an evaluate (tuser = 1) at t.
//   Master stream (m_*): one transaction per evaluate, the curve point.
//   cfg_wr_en/cfg_wr_data set active_points (n); user writes only while idle.
// Timing
//   A load gives no result. An evaluate reduces level by level, one lerp per
//   cycle from the control store on the first level and from the single read
//   port of the work store on later ones; each level after the first waits for
//   the read/multiply/write pipeline to retire. One evaluate is worked at
//   a time.
// Reset
//   rst_n clears control state and sets n to one. Point memories are not
//   cleared; a point must be loaded before an evaluate uses it.
// Stall
//   The result waits in the output register while m_tready is low; the block
//   keeps accepting transactions, but a second finished result holds in an
//   internal register, with s_tready low, until the output register frees.

module bezier_de_casteljau_eval_core #(
    parameter int MAX_POINTS  = bzdc_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = bzdc_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] point_index, [35:4] point_x, [67:36] point_y, [84:68] curve_param
    input  logic [bzdc_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] cmd
    input  logic [bzdc_pkg::S_USER_W-1:0]  s_tuser,
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] curve_x, [63:32] curve_y
    output logic [bzdc_pkg::M_DATA_W-1:0]  m_tdata,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [bzdc_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int IW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int AW     = (CNT_W > bzdc_pkg::CFG_W) ? CNT_W : bzdc_pkg::CFG_W;
    localparam int PI_W   = (CNT_W > bzdc_pkg::IDX_W) ? CNT_W : bzdc_pkg::IDX_W;
    localparam int EXT_W  = (COORD_WIDTH > bzdc_pkg::XY_W) ? COORD_WIDTH : bzdc_pkg::XY_W;
    localparam int ENT_W  = 2 * COORD_WIDTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Input fields
    logic                                 in_cmd;
    logic [bzdc_pkg::IDX_W-1:0]           in_idx;
    logic signed [bzdc_pkg::XY_W-1:0]     in_x;
    logic signed [bzdc_pkg::XY_W-1:0]     in_y;
    logic [bzdc_pkg::T_W-1:0]             in_t;
    logic                                 in_fire;

    assign in_cmd  = s_tuser[0];
    assign in_idx  = s_tdata[bzdc_pkg::IDX_LSB +: bzdc_pkg::IDX_W];
    assign in_x    = s_tdata[bzdc_pkg::PX_LSB +: bzdc_pkg::XY_W];
    assign in_y    = s_tdata[bzdc_pkg::PY_LSB +: bzdc_pkg::XY_W];
    assign in_t    = s_tdata[bzdc_pkg::T_LSB +: bzdc_pkg::T_W];
    assign in_fire = s_tvalid && s_tready;

    // Control state
    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [bzdc_pkg::CFG_W-1:0] active_points_reg;
    logic [CNT_W-1:0]           len_reg;
    logic [IW-1:0]              j_reg;
    logic                       src_ctrl_reg;
    logic [bzdc_pkg::T_W-1:0]   t_reg;

    // Pipeline stage flags
    logic          s1_valid_reg;
    logic          s1_first_reg;
    logic          s1_final_reg;
    logic          s1_single_reg;
    logic          s1_ctrl_reg;
    logic [IW-1:0] s1_idx_reg;
    logic          s2_valid_reg;
    logic          s2_final_reg;
    logic [IW-1:0] s2_addr_reg;

    // Memories and read data
    logic [ENT_W-1:0] ctrl_mem [MAX_POINTS];
    logic [ENT_W-1:0] work_mem [MAX_POINTS];
    logic [ENT_W-1:0] ctrl_rd_reg;
    logic [ENT_W-1:0] work_rd_reg;
    logic [ENT_W-1:0] res_reg;

    logic                 m_tvalid_reg;
    logic [bzdc_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Clamp active_points to 1..MAX_POINTS
    logic [AW-1:0]    ap_wide;
    logic [AW-1:0]    n_wide;
    logic [CNT_W-1:0] n_eval;

    assign ap_wide = AW'(active_points_reg);
    always_comb
    begin
        if (ap_wide == '0)
        begin
            n_wide = AW'(1);
        end
        else if (ap_wide > AW'(MAX_POINTS))
        begin
            n_wide = AW'(MAX_POINTS);
        end
        else
        begin
            n_wide = ap_wide;
        end
    end
    assign n_eval = n_wide[CNT_W-1:0];

    // Saturate t to 1.0
    logic [bzdc_pkg::T_W-1:0] t_sat;
    assign t_sat = (in_t > bzdc_pkg::T_ONE) ? bzdc_pkg::T_ONE : in_t;

    // Load path: index check and coordinate narrowing
    logic [PI_W-1:0]              ld_idx_wide;
    logic                         ld_we;
    logic [IW-1:0]                ld_addr;
    logic signed [EXT_W-1:0]      ld_x_wide;
    logic signed [EXT_W-1:0]      ld_y_wide;

    assign ld_idx_wide = PI_W'(in_idx);
    assign ld_we       = in_fire && (in_cmd == bzdc_pkg::CMD_LOAD)
                         && (ld_idx_wide < PI_W'(MAX_POINTS));
    assign ld_addr     = ld_idx_wide[IW-1:0];
    assign ld_x_wide   = EXT_W'(in_x);
    assign ld_y_wide   = EXT_W'(in_y);

    // Sequencer issue decisions
    logic eval_start;
    logic single_start;
    logic run_issue;
    logic level_end;
    logic [IW-1:0] rd_addr;

    assign eval_start   = in_fire && (in_cmd == bzdc_pkg::CMD_EVAL);
    assign single_start = eval_start && (n_eval == CNT_W'(1));
    assign run_issue    = (state_reg == ST_RUN)
                          && ((j_reg != '0) || (!s1_valid_reg && !s2_valid_reg));
    assign level_end    = (CNT_W'(j_reg) + CNT_W'(1)) == len_reg;
    assign rd_addr      = (state_reg == ST_RUN) ? j_reg : '0;

    // Lerp lanes
    logic signed [COORD_WIDTH-1:0] q_x;
    logic signed [COORD_WIDTH-1:0] q_y;
    logic signed [COORD_WIDTH-1:0] sum_x;
    logic signed [COORD_WIDTH-1:0] sum_y;
    bzdc_pkg::lerp_ctl_t           lerp_ctl;

    assign q_x = s1_ctrl_reg ? ctrl_rd_reg[COORD_WIDTH-1:0] : work_rd_reg[COORD_WIDTH-1:0];
    assign q_y = s1_ctrl_reg ? ctrl_rd_reg[ENT_W-1:COORD_WIDTH]
                             : work_rd_reg[ENT_W-1:COORD_WIDTH];
    assign lerp_ctl.take = s1_valid_reg;
    assign lerp_ctl.step = s1_valid_reg && !s1_first_reg;

    bzdc_lerp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lerp_x (
        .clk (clk),
        .ctl (lerp_ctl),
        .q   (q_x),
        .t   (t_reg),
        .sum (sum_x)
    );

    bzdc_lerp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lerp_y (
        .clk (clk),
        .ctl (lerp_ctl),
        .q   (q_y),
        .t   (t_reg),
        .sum (sum_y)
    );

    logic res_single;
    logic res_final;
    assign res_single = s1_valid_reg && s1_single_reg;
    assign res_final  = s2_valid_reg && s2_final_reg;

    // Control point memory: load writes, reduction reads
    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            ctrl_mem[ld_addr] <= {ld_y_wide[COORD_WIDTH-1:0], ld_x_wide[COORD_WIDTH-1:0]};
        end
        ctrl_rd_reg <= ctrl_mem[rd_addr];
    end

    // Work memory: lerp results written back, read by later levels
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            work_mem[s2_addr_reg] <= {sum_y, sum_x};
        end
        work_rd_reg <= work_mem[rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (single_start)
                begin
                    state_next = ST_FLUSH;
                end
                else if (eval_start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (run_issue && level_end && (len_reg == CNT_W'(2)))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (res_single || res_final)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer and pipeline control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            active_points_reg <= bzdc_pkg::CFG_W'(1);
            len_reg           <= '0;
            j_reg             <= '0;
            src_ctrl_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                active_points_reg <= cfg_wr_data;
            end

            // Level and index counters
            if (eval_start)
            begin
                len_reg      <= n_eval;
                j_reg        <= '0;
                src_ctrl_reg <= 1'b1;
            end
            else if (run_issue)
            begin
                if (level_end)
                begin
                    len_reg      <= len_reg - CNT_W'(1);
                    j_reg        <= '0;
                    src_ctrl_reg <= 1'b0;
                end
                else
                begin
                    j_reg <= j_reg + IW'(1);
                end
            end

            s1_valid_reg <= run_issue || single_start;
            s2_valid_reg <= s1_valid_reg && !s1_first_reg;

            // Output register
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result formatting to 32-bit outputs
    logic signed [EXT_W-1:0] res_x_wide;
    logic signed [EXT_W-1:0] res_y_wide;
    assign res_x_wide = EXT_W'($signed(res_reg[COORD_WIDTH-1:0]));
    assign res_y_wide = EXT_W'($signed(res_reg[ENT_W-1:COORD_WIDTH]));

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            t_reg <= t_sat;
        end

        s1_first_reg  <= (j_reg == '0) || single_start;
        s1_final_reg  <= (len_reg == CNT_W'(2));
        s1_single_reg <= single_start;
        s1_ctrl_reg   <= src_ctrl_reg || single_start;
        s1_idx_reg    <= rd_addr;

        s2_final_reg  <= s1_final_reg;
        s2_addr_reg   <= s1_idx_reg - IW'(1);

        if (res_single)
        begin
            res_reg <= {q_y, q_x};
        end
        else if (res_final)
        begin
            res_reg <= {sum_y, sum_x};
        end

        if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {res_y_wide[bzdc_pkg::XY_W-1:0], res_x_wide[bzdc_pkg::XY_W-1:0]};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/bzdc_checker.sv]
// Port-level checks for bezier_de_casteljau_eval_core, attached by bind.
// Depends on bzdc_pkg for port widths.

module bzdc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bzdc_pkg::S_USER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bzdc_pkg::M_DATA_W-1:0] m_tdata
);

    // A stalled result transaction holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An accepted evaluate makes the block busy on the next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == bzdc_pkg::CMD_EVAL) |=> !s_tready)
        else $error("evaluate did not occupy the block");

    // A load completes and leaves the block ready in the next cycle
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == bzdc_pkg::CMD_LOAD) |=> s_tready)
        else $error("load stalled the input");

    // A new result only appears when the block was busy in the previous cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an evaluate in progress");

endmodule

bind bezier_de_casteljau_eval_core bzdc_checker u_bzdc_checker (.*);

[bench/tb_top.sv]
// Self-checking bench for bezier_de_casteljau_eval_core: loads control points,
// evaluates curves at many t and point counts, and checks every curve point.
// Depends on bzdc_pkg and the evaluator RTL only.
`timescale 1ns / 100ps

module tb_top;

    localparam int  NPTS        = 16;
    localparam int  DRAIN_WAIT  = 200;      // covers the longest evaluate latency
    localparam int  CYCLE_LIMIT = 1500000;

    // One slave-side transaction
    typedef struct {
        logic                       cmd;
        logic [bzdc_pkg::IDX_W-1:0] idx;
        logic [bzdc_pkg::XY_W-1:0]  x;
        logic [bzdc_pkg::XY_W-1:0]  y;
        logic [bzdc_pkg::T_W-1:0]   t;
    } stream_cmd_t;

    typedef struct packed {
        logic [bzdc_pkg::XY_W-1:0] y;
        logic [bzdc_pkg::XY_W-1:0] x;
    } curve_pt_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [bzdc_pkg::S_DATA_W-1:0] s_tdata     = '0;
    logic [bzdc_pkg::S_USER_W-1:0] s_tuser     = '0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [bzdc_pkg::M_DATA_W-1:0] m_tdata;
    logic                          cfg_wr_en   = 1'b0;
    logic [bzdc_pkg::CFG_W-1:0]    cfg_wr_data = '0;

    // Bench-side copy of the block state
    logic signed [bzdc_pkg::XY_W-1:0] ctrl_x [NPTS];
    logic signed [bzdc_pkg::XY_W-1:0] ctrl_y [NPTS];
    logic [bzdc_pkg::CFG_W-1:0]       point_count = 5'd1;

    stream_cmd_t cmd_queue[$];
    curve_pt_t   curve_queue[$];

    stream_cmd_t drv_cur     = '{default: '0};
    bit          drv_busy    = 1'b0;
    int unsigned drv_gap     = 0;
    int unsigned rdy_left    = 0;
    bit          no_idle     = 1'b0;
    int unsigned errors      = 0;
    int unsigned cycle_count = 0;

    int phase_counts [13] = '{0, 31, 17, 2, 3, 16, 5, 8, 1, 12, 16, 4, 7};

    bezier_de_casteljau_eval_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // One reduction step: p + floor(t * (q - p) / 2^16)
    function automatic longint lerp_step(longint p, longint q, longint t);
        longint d;
        d = (q - p) * t;
        return p + (d >>> 16);
    endfunction

    // Curve point at t over the active control points
    function automatic curve_pt_t eval_curve(logic [bzdc_pkg::T_W-1:0] t_raw);
        longint    wx [NPTS];
        longint    wy [NPTS];
        longint    tv;
        int        n;
        int        i;
        int        len;
        curve_pt_t r;
        tv = (t_raw > bzdc_pkg::T_ONE) ? longint'(bzdc_pkg::T_ONE) : longint'(t_raw);
        n = int'(point_count);
        if (n < 1)
            n = 1;
        if (n > NPTS)
            n = NPTS;
        for (i = 0; i < n; i++)
        begin
            wx[i] = longint'(ctrl_x[i]);
            wy[i] = longint'(ctrl_y[i]);
        end
        for (len = n; len > 1; len--)
        begin
            for (i = 0; i + 1 < len; i++)
            begin
                wx[i] = lerp_step(wx[i], wx[i + 1], tv);
                wy[i] = lerp_step(wy[i], wy[i + 1], tv);
            end
        end
        r.x = 32'(wx[0]);
        r.y = 32'(wy[0]);
        return r;
    endfunction

    // Update the bench state for one accepted transaction
    function automatic void apply_cmd(stream_cmd_t c);
        if (c.cmd == bzdc_pkg::CMD_LOAD)
        begin
            ctrl_x[c.idx] = c.x;
            ctrl_y[c.idx] = c.y;
        end
        else
            curve_queue.insert(curve_queue.size(), eval_curve(c.t));
    endfunction

    // Slave-side driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_cmd(drv_cur);
                drv_busy = 1'b0;
            end
            if (!drv_busy)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (cmd_queue.size() > 0)
                begin
                    drv_cur  = cmd_queue.pop_front();
                    drv_busy = 1'b1;
                    drv_gap  = no_idle ? 0 : gap_len();
                end
            end
            s_tvalid <= drv_busy;
            s_tdata  <= {3'b000, drv_cur.t, drv_cur.y, drv_cur.x, drv_cur.idx};
            s_tuser  <= drv_cur.cmd;
        end
    end

    // Master-side monitor and checker
    always @(posedge clk)
    begin : monitor
        curve_pt_t want;
        bit        next_ready;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (curve_queue.size() == 0)
                begin
                    $display("%0t: unexpected result x %h y %h", $time,
                             m_tdata[31:0], m_tdata[63:32]);
                    errors++;
                end
                else
                begin
                    want = curve_queue.pop_front();
                    if (m_tdata[31:0] !== want.x)
                    begin
                        $display("%0t: curve_x expected %h got %h", $time,
                                 want.x, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== want.y)
                    begin
                        $display("%0t: curve_y expected %h got %h", $time,
                                 want.y, m_tdata[63:32]);
                        errors++;
                    end
                end
            end
            if (rdy_left > 0)
            begin
                rdy_left--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    rdy_left = gap_len();
            end
            m_tready <= next_ready;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit bench_idle();
        return cmd_queue.size() == 0 && !drv_busy && curve_queue.size() == 0;
    endfunction

    // Wait for all results, then let any trailing load retire
    task automatic drain();
        while (!bench_idle())
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_count(logic [bzdc_pkg::CFG_W-1:0] v);
        drain();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        point_count  = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic push_load(int idx, logic [bzdc_pkg::XY_W-1:0] x,
                             logic [bzdc_pkg::XY_W-1:0] y);
        stream_cmd_t c;
        c.cmd = bzdc_pkg::CMD_LOAD;
        c.idx = bzdc_pkg::IDX_W'(idx);
        c.x   = x;
        c.y   = y;
        c.t   = bzdc_pkg::T_W'($urandom());
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic push_eval(logic [bzdc_pkg::T_W-1:0] t);
        stream_cmd_t c;
        c.cmd = bzdc_pkg::CMD_EVAL;
        c.idx = bzdc_pkg::IDX_W'($urandom());
        c.x   = $urandom();
        c.y   = $urandom();
        c.t   = t;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    function automatic logic [bzdc_pkg::XY_W-1:0] rand_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        else if (r < 40)
            return 32'($signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000);
        else
            return $urandom();
    endfunction

    function automatic logic [bzdc_pkg::T_W-1:0] rand_param();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return bzdc_pkg::T_ONE;
        else if (r < 24)
            return bzdc_pkg::T_W'($urandom_range(65537, 131071));
        else if (r < 30)
            return ($urandom_range(0, 1) == 0) ? bzdc_pkg::T_W'(1) : bzdc_pkg::T_W'(65535);
        else
            return bzdc_pkg::T_W'($urandom_range(0, 65536));
    endfunction

    // Mostly curve reloads followed by evaluates, plus single loose commands
    task automatic fill_random(int count);
        int made;
        int n;
        int k;
        int j;
        made = 0;
        n = int'(point_count);
        if (n < 1)
            n = 1;
        if (n > NPTS)
            n = NPTS;
        while (made < count)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                k = $urandom_range(1, n);
                for (j = 0; j < k; j++)
                    push_load($urandom_range(0, n - 1), rand_coord(), rand_coord());
                made += k;
                k = $urandom_range(1, 3);
                for (j = 0; j < k; j++)
                    push_eval(rand_param());
                made += k;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                push_load($urandom_range(0, NPTS - 1), rand_coord(), rand_coord());
                made++;
            end
            else
            begin
                push_eval(rand_param());
                made++;
            end
        end
    endtask

    // Stimulus sequence
    initial
    begin : stimulus
        int p;
        int i;
        int half;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every point is loaded before any evaluate; extremes in the first four
        push_load(0, 32'h7FFF_FFFF, 32'h8000_0000);
        push_load(1, 32'h8000_0000, 32'h7FFF_FFFF);
        push_load(2, 32'h0000_0000, 32'hFFFF_FFFF);
        push_load(3, 32'hFFFF_FFFF, 32'h0000_0000);
        for (i = 4; i < NPTS; i++)
            push_load(i, $urandom(), $urandom());
        // Single point after reset returns point 0
        push_eval('0);
        push_eval(bzdc_pkg::T_ONE);

        write_count(5'd16);
        push_eval('0);
        push_eval(bzdc_pkg::T_ONE);
        push_eval(17'h1FFFF);   // above one, saturates
        push_eval(bzdc_pkg::T_W'(32768));
        push_eval(bzdc_pkg::T_W'(1));

        // Random phases over several point counts, out-of-range ones included
        for (p = 0; p < 13; p++)
        begin
            write_count(bzdc_pkg::CFG_W'(phase_counts[p]));
            no_idle = (p == 5);
            if (p == 7)
            begin
                // Sender holds off until every result is back, mid-phase
                half = 44;
                fill_random(half);
                while (!bench_idle())
                    @(posedge clk);
                fill_random(87 - half);
            end
            else
                fill_random(87);
        end
        no_idle = 1'b0;

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
